// ===== hw/rtl/itoa_pkg.sv =====
package itoa_pkg;

  // Digit storage: up to ten decimal or eight hex digits, four bits each
  localparam int DIG_N   = 10;
  localparam int DIG_W   = 4 * DIG_N;
  localparam int HEX_N   = 8;
  localparam int CNT_W   = 4;

  // Descriptor queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  // Reciprocal of ten for the digit step: q = (x * RECIP10) >> RECIP_SH
  localparam logic [63:0] RECIP10  = 64'h0000_0000_CCCC_CCCD;
  localparam int          RECIP_SH = 35;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;

  localparam logic [CNT_W-1:0] DEC_LIMIT = CNT_W'(DIG_N);
  localparam logic [CNT_W-1:0] HEX_LIMIT = CNT_W'(HEX_N);

  // One converted number, digits most significant at the top
  typedef struct packed {
    logic [DIG_W-1:0] digits;
    logic [CNT_W-1:0] ndig;
    logic             neg;
    logic             hex;
    logic             upper;
    logic             pad8;
    logic             padzero;
    logic             prefix;
  } itoa_desc_t;

  // Queue handshake from the front
  typedef struct packed {
    logic       push;
    itoa_desc_t desc;
  } itoa_push_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SIGN,
    BK_PRE0,
    BK_PREX,
    BK_PAD,
    BK_DIG
  } bk_state_t;

  // ASCII for one digit value
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0, d};
    end
    return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

// ===== hw/rtl/itoa_front.sv =====
module itoa_front
  import itoa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic         in_req_type,
  input  logic [31:0]  in_value,
  input  logic         in_upper_case,
  input  logic         in_pad_to_eight,
  input  logic         in_pad_with_zero,
  input  logic         in_with_prefix,
  input  logic         q_full,
  output itoa_push_t   q_push
);

  fe_state_t  state_r, state_nxt;
  logic [31:0] mag_r, mag_nxt;
  itoa_desc_t desc_r, desc_nxt;

  logic        accept;
  logic [63:0] prod;
  logic [28:0] quot;
  logic [31:0] quot10;
  logic [3:0]  digit;
  logic [31:0] mag_next_digit;
  logic [CNT_W-1:0] ndig_inc;
  logic        conv_done;

  assign busy   = (state_r != FE_IDLE);
  assign accept = start && !busy;

  // One digit per cycle: divide by ten through the reciprocal, or take a nibble
  assign prod   = {32'b0, mag_r} * RECIP10;
  assign quot   = prod[63:RECIP_SH];
  assign quot10 = ({3'b0, quot} << 3) + ({3'b0, quot} << 1);
  assign digit  = desc_r.hex ? mag_r[3:0] : (mag_r[3:0] - quot10[3:0]);
  assign mag_next_digit = desc_r.hex ? {4'b0, mag_r[31:4]} : {3'b0, quot};
  assign ndig_inc  = desc_r.ndig + CNT_W'(1);
  assign conv_done = (mag_next_digit == 32'd0) ||
                     (ndig_inc == (desc_r.hex ? HEX_LIMIT : DEC_LIMIT));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: begin
        if (accept) state_nxt = FE_CONV;
      end
      FE_CONV: begin
        if (conv_done) state_nxt = FE_PUSH;
      end
      FE_PUSH: begin
        if (!q_full) state_nxt = FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  // Datapath and queue push
  always_comb begin
    mag_nxt     = mag_r;
    desc_nxt    = desc_r;
    q_push.push = 1'b0;
    q_push.desc = desc_r;
    case (state_r)
      FE_IDLE: begin
        if (accept) begin
          desc_nxt.digits  = '0;
          desc_nxt.ndig    = '0;
          desc_nxt.hex     = in_req_type;
          desc_nxt.neg     = !in_req_type && in_value[31];
          desc_nxt.upper   = in_upper_case;
          desc_nxt.pad8    = in_pad_to_eight;
          desc_nxt.padzero = in_pad_with_zero;
          desc_nxt.prefix  = in_with_prefix;
          mag_nxt = (!in_req_type && in_value[31]) ? (32'd0 - in_value) : in_value;
        end
      end
      FE_CONV: begin
        desc_nxt.digits = {digit, desc_r.digits[DIG_W-1:4]};
        desc_nxt.ndig   = ndig_inc;
        mag_nxt         = mag_next_digit;
      end
      FE_PUSH: begin
        q_push.push = !q_full;
      end
      default: begin
        q_push.push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    desc_r <= desc_nxt;
  end

endmodule

// ===== hw/rtl/itoa_queue.sv =====
module itoa_queue
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  itoa_push_t q_push,
  output logic       q_full,
  output logic       q_empty,
  input  logic       q_pop,
  output itoa_desc_t q_head
);

  itoa_desc_t      mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic            do_push, do_pop;

  assign q_full  = (count_r == Q_CW'(Q_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_push.push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + Q_CW'(1);
        2'b01:   count_r <= count_r - Q_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_push.desc;
  end

endmodule

// ===== hw/rtl/itoa_back.sv =====
module itoa_back
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  itoa_desc_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic       out_last_char
);

  bk_state_t        state_r, state_nxt;
  logic [DIG_W-1:0] digits_r, digits_nxt;
  logic [CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic             upper_r, upper_nxt;
  logic             padzero_r, padzero_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  logic             head_pad;

  assign head_pad = q_head.pad8 && (q_head.ndig != HEX_LIMIT);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (!q_head.hex) state_nxt = q_head.neg ? BK_SIGN : BK_DIG;
          else if (q_head.prefix) state_nxt = BK_PRE0;
          else state_nxt = head_pad ? BK_PAD : BK_DIG;
        end
      end
      BK_SIGN: state_nxt = BK_DIG;
      BK_PRE0: state_nxt = BK_PREX;
      BK_PREX: state_nxt = (pcnt_r != '0) ? BK_PAD : BK_DIG;
      BK_PAD:  state_nxt = (pcnt_r == CNT_W'(1)) ? BK_DIG : BK_PAD;
      BK_DIG:  state_nxt = (dcnt_r == CNT_W'(1)) ? BK_IDLE : BK_DIG;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Character emission and descriptor load
  always_comb begin
    digits_nxt  = digits_r;
    dcnt_nxt    = dcnt_r;
    pcnt_nxt    = pcnt_r;
    upper_nxt   = upper_r;
    padzero_nxt = padzero_r;
    valid_nxt   = 1'b0;
    char_nxt    = char_r;
    last_nxt    = 1'b0;
    q_pop       = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          digits_nxt  = q_head.digits;
          dcnt_nxt    = q_head.ndig;
          upper_nxt   = q_head.upper;
          padzero_nxt = q_head.padzero;
          pcnt_nxt    = (q_head.hex && head_pad) ? (HEX_LIMIT - q_head.ndig) : '0;
        end
      end
      BK_SIGN: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_MINUS;
      end
      BK_PRE0: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_ZERO;
      end
      BK_PREX: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_X;
      end
      BK_PAD: begin
        valid_nxt = 1'b1;
        char_nxt  = padzero_r ? CH_ZERO : CH_SPACE;
        pcnt_nxt  = pcnt_r - CNT_W'(1);
      end
      BK_DIG: begin
        valid_nxt  = 1'b1;
        char_nxt   = digit_char(digits_r[DIG_W-1 -: 4], upper_r);
        last_nxt   = (dcnt_r == CNT_W'(1));
        digits_nxt = {digits_r[DIG_W-5:0], 4'b0};
        dcnt_nxt   = dcnt_r - CNT_W'(1);
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  assign out_valid     = valid_r;
  assign out_char      = char_r;
  assign out_last_char = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r  <= digits_nxt;
    dcnt_r    <= dcnt_nxt;
    pcnt_r    <= pcnt_nxt;
    upper_r   <= upper_nxt;
    padzero_r <= padzero_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

endmodule

// ===== hw/rtl/integer_to_ascii_formatter_unit.sv =====
// Integer to ASCII formatter.
// Command channel: a number and its format options are taken at a rising
// edge with start high and busy low. Result channel: one ASCII character per
// cycle on out_char, marked by out_valid, most significant first, with
// out_last_char on the final character of the number.
// The front converts the number one digit per cycle (divide by ten through a
// reciprocal multiply in decimal mode, one nibble in hex mode) and stays busy
// through conversion and its push state; a two-entry descriptor queue lets it
// take the next number while the back still writes out characters.
// From a transfer to the first character, back idle, the number passes the
// front's conversion and push states, the queue, the back's idle state and
// its character register. The back emits one character per cycle within a
// number and passes through its idle state between numbers. A number has at
// most ten decimal digits in the front; the most negative decimal value gives
// eleven characters in the back. With the queue full the front holds its push
// state and busy stays high.
// Synchronous reset clears the front, the queue and the back; no character
// is in flight afterwards. The receiver cannot hold results off: each
// character is valid for exactly one cycle.
module integer_to_ascii_formatter_unit
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_value,
  input  logic        in_upper_case,
  input  logic        in_pad_to_eight,
  input  logic        in_pad_with_zero,
  input  logic        in_with_prefix,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_last_char
);

  itoa_push_t q_push;
  itoa_desc_t q_head;
  logic       q_full, q_empty, q_pop;

  // Conversion front
  itoa_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_value         (in_value),
    .in_upper_case    (in_upper_case),
    .in_pad_to_eight  (in_pad_to_eight),
    .in_pad_with_zero (in_pad_with_zero),
    .in_with_prefix   (in_with_prefix),
    .q_full           (q_full),
    .q_push           (q_push)
  );

  // Descriptor queue
  itoa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  // Character emitter
  itoa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

// ===== hw/rtl/itoa_checker.sv =====
module itoa_checker
  import itoa_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_char,
  input logic       out_last_char
);

  // Reset leaves no character on the output
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("character strobe right after reset");

  // A transfer makes the front busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("front not busy after a transfer");

  // Characters of one number come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |=> out_valid)
    else $error("gap inside a number");

  // Sign and prefix letter never end a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == CH_MINUS || out_char == CH_X) |-> !out_last_char)
    else $error("sign or prefix marked as last character");

  // The prefix letter follows a zero character
  a_prefix_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == CH_X |-> $past(out_valid) && $past(out_char) == CH_ZERO)
    else $error("prefix letter without leading zero");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_char      (out_char),
  .out_last_char (out_last_char)
);
